>>> hdl/daq_ebd_pkg.sv
// ----------------------------------------------------------------------------
// daq_ebd_pkg
// Types, constants and helpers shared by the event bank deframer.
// ----------------------------------------------------------------------------
package daq_ebd_pkg;

   localparam int MAX_CRATES   = 32;
   localparam int CRATE_CNT_W  = 12;
   localparam int RUN_WORDS    = 3;

   // response queue
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // word positions inside an event
   localparam logic [31:0] WORD_LEN      = 32'd0;
   localparam logic [31:0] WORD_TYPE     = 32'd1;
   localparam logic [31:0] WORD_TRIG_LEN = 32'd2;
   localparam logic [31:0] WORD_TRIG_CNT = 32'd3;
   localparam logic [31:0] WORD_EVNUM    = 32'd4;

   localparam logic [31:0] FIRST_BANK_POS  = 32'd2;
   localparam logic [32:0] TRIG_POS_OFFSET = 33'd3;

   localparam logic [1:0]  FMT_V2 = 2'd2;

   localparam logic [15:0] TAG_RESERVED_BASE = 16'hff00;
   localparam logic [15:0] TAG_PRESTART      = 16'hffd1;
   localparam logic [15:0] TAG_GO            = 16'hffd2;
   localparam logic [15:0] TAG_END           = 16'hffd4;
   localparam logic [15:0] TAG_PHYS_A        = 16'hff50;
   localparam logic [15:0] TAG_PHYS_B        = 16'hff58;
   localparam logic [15:0] TAG_PHYS_C        = 16'hff70;
   localparam logic [15:0] TRIGGER_EVENT     = 16'd1;
   localparam logic [15:0] HEADER_MARK       = 16'h10cc;

   localparam logic KIND_BANK    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef enum logic [1:0] {
      ST_OK             = 2'd0,
      ST_BAD_CRATE      = 2'd1,
      ST_COUNT_MISMATCH = 2'd2,
      ST_BAD_MARK       = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CSR_FORMAT_VERSION   = 3'd0,
      CSR_MAX_PHYSICS_TYPE = 3'd1,
      CSR_PRESTART_TYPE    = 3'd2,
      CSR_GO_TYPE          = 3'd3,
      CSR_END_TYPE         = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [1:0]  format_version;
      logic [15:0] max_physics_type;
      logic [15:0] prestart_type;
      logic [15:0] go_type;
      logic [15:0] end_type;
   } cfg_type;

   typedef struct packed {
      logic                   kind;
      logic [11:0]            crate_id;
      logic [31:0]            bank_position;
      logic [31:0]            bank_length;
      logic [15:0]            event_code;
      logic [31:0]            event_number;
      logic [CRATE_CNT_W-1:0] crate_count;
      status_type             status;
      logic [31:0]            run_time;
      logic [31:0]            run_number;
      logic [31:0]            run_kind;
      logic                   last;
   } rsp_item_type;

   // what one accepted word produces: an optional bank descriptor, then an
   // optional event summary
   typedef struct packed {
      logic         desc_valid;
      logic         sum_valid;
      rsp_item_type desc;
      rsp_item_type sum;
   } push_type;

   function automatic logic [15:0] v3_decode_type(input logic [15:0] tag,
                                                  input cfg_type   cfg);
      logic [15:0] result;
      if (tag < TAG_RESERVED_BASE) begin
         result = tag;
      end else if (tag == TAG_PRESTART) begin
         result = cfg.prestart_type;
      end else if (tag == TAG_GO) begin
         result = cfg.go_type;
      end else if (tag == TAG_END) begin
         result = cfg.end_type;
      end else if (tag == TAG_PHYS_A || tag == TAG_PHYS_B || tag == TAG_PHYS_C) begin
         result = TRIGGER_EVENT;
      end else begin
         result = '0;
      end
      return result;
   endfunction

endpackage

>>> hdl/daq_ebd_if.sv
// ----------------------------------------------------------------------------
// daq_ebd_if
// Valid/ready channels for stream words in and bank/summary responses out.
// ----------------------------------------------------------------------------
interface daq_ebd_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] data_word;

   modport source (output valid, output data_word, input ready);
   modport sink   (input valid, input data_word, output ready);
endinterface

interface daq_ebd_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [11:0] crate_id;
   logic [31:0] bank_position;
   logic [31:0] bank_length;
   logic [15:0] event_code;
   logic [31:0] event_number;
   logic [11:0] crate_count;
   logic [1:0]  status;
   logic [31:0] run_time;
   logic [31:0] run_number;
   logic [31:0] run_kind;
   logic        last;

   modport source (output valid, output kind, output crate_id, output bank_position,
                   output bank_length, output event_code, output event_number,
                   output crate_count, output status, output run_time,
                   output run_number, output run_kind, output last, input ready);
   modport sink   (input valid, input kind, input crate_id, input bank_position,
                   input bank_length, input event_code, input event_number,
                   input crate_count, input status, input run_time,
                   input run_number, input run_kind, input last, output ready);
endinterface

>>> hdl/daq_event_bank_deframer.sv
// ----------------------------------------------------------------------------
// daq_event_bank_deframer
// Event stream deframer: crate bank descriptors and per-event summaries.
// ----------------------------------------------------------------------------
// Takes one stream word per cycle on req_ch and decodes it in the same cycle;
// its responses are written into a four-entry response queue and appear on
// rsp_ch from the next cycle on. A word gives no response, a bank descriptor,
// an event summary, or a descriptor followed by a summary when a bank header
// is also the last word of the event. The queue drains one response per
// cycle while rsp_ch.ready is high, and req_ch.ready is high while at least
// two entries are free, so the block sustains one word per cycle as long as
// rsp_ch keeps up; a word that gives two responses puts both into the queue
// at once. Registers are written through csr_we/csr_index/csr_wdata and
// should change only between events.
// ----------------------------------------------------------------------------
module daq_event_bank_deframer import daq_ebd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   daq_ebd_req_if.sink          req_ch,
   daq_ebd_rsp_if.source        rsp_ch,
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [15:0]          csr_wdata
);

   cfg_type      cfg_ff, cfg_in;
   push_type     push;
   rsp_item_type head;
   logic         head_valid;
   logic         two_free;
   logic         accept;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_FORMAT_VERSION:   cfg_in.format_version   = csr_wdata[1:0];
            CSR_MAX_PHYSICS_TYPE: cfg_in.max_physics_type = csr_wdata;
            CSR_PRESTART_TYPE:    cfg_in.prestart_type    = csr_wdata;
            CSR_GO_TYPE:          cfg_in.go_type          = csr_wdata;
            CSR_END_TYPE:         cfg_in.end_type         = csr_wdata;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.format_version   <= 2'd3;
         cfg_ff.max_physics_type <= 16'd15;
         cfg_ff.prestart_type    <= 16'd17;
         cfg_ff.go_type          <= 16'd18;
         cfg_ff.end_type         <= 16'd20;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_ch.ready = two_free;
   assign accept       = req_ch.valid && two_free;

   daq_ebd_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .accept    (accept),
      .data_word (req_ch.data_word),
      .push      (push)
   );

   daq_ebd_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (rsp_ch.ready),
      .head       (head),
      .head_valid (head_valid),
      .two_free   (two_free)
   );

   assign rsp_ch.valid         = head_valid;
   assign rsp_ch.kind          = head.kind;
   assign rsp_ch.crate_id      = head.crate_id;
   assign rsp_ch.bank_position = head.bank_position;
   assign rsp_ch.bank_length   = head.bank_length;
   assign rsp_ch.event_code    = head.event_code;
   assign rsp_ch.event_number  = head.event_number;
   assign rsp_ch.crate_count   = head.crate_count;
   assign rsp_ch.status        = head.status;
   assign rsp_ch.run_time      = head.run_time;
   assign rsp_ch.run_number    = head.run_number;
   assign rsp_ch.run_kind      = head.run_kind;
   assign rsp_ch.last          = head.last;

endmodule

>>> hdl/daq_ebd_parse.sv
// ----------------------------------------------------------------------------
// daq_ebd_parse
// Per-word event parser: header decode, crate bank walk and event summary.
// ----------------------------------------------------------------------------
module daq_ebd_parse import daq_ebd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        accept,
   input  logic [31:0] data_word,
   output push_type    push
);

   logic [31:0]            word_index_ff,  word_index_in;
   logic [31:0]            event_words_ff, event_words_in;
   logic [15:0]            cur_type_ff,    cur_type_in;
   logic [31:0]            next_pos_ff,    next_pos_in;
   logic [31:0]            pend_len_ff,    pend_len_in;
   logic [CRATE_CNT_W-1:0] banks_ff,       banks_in;
   logic [7:0]             trig_cnt_ff,    trig_cnt_in;
   logic [31:0]            v3_cnt_ff,      v3_cnt_in;
   logic [31:0]            evnum_ff,       evnum_in;
   logic [31:0]            run_info_ff [RUN_WORDS];
   logic [31:0]            run_info_in [RUN_WORDS];
   status_type             status_ff,      status_in;
   logic                   v2_ff,          v2_in;
   logic                   phys_ff,        phys_in;
   logic                   prestart_ff,    prestart_in;
   logic                   armed_ff,       armed_in;
   logic                   walk_ff,        walk_in;
   logic                   len_seen_ff,    len_seen_in;

   logic [15:0]            type_dec;
   logic [32:0]            trig_pos;
   logic [11:0]            bank_id;
   logic [31:0]            bank_len;
   logic [32:0]            bank_next;
   logic [31:0]            last_index;

   always_comb begin
      word_index_in  = word_index_ff;
      event_words_in = event_words_ff;
      cur_type_in    = cur_type_ff;
      next_pos_in    = next_pos_ff;
      pend_len_in    = pend_len_ff;
      banks_in       = banks_ff;
      trig_cnt_in    = trig_cnt_ff;
      v3_cnt_in      = v3_cnt_ff;
      evnum_in       = evnum_ff;
      run_info_in    = run_info_ff;
      status_in      = status_ff;
      v2_in          = v2_ff;
      phys_in        = phys_ff;
      prestart_in    = prestart_ff;
      armed_in       = armed_ff;
      walk_in        = walk_ff;
      len_seen_in    = len_seen_ff;
      type_dec       = v2_ff ? data_word[31:16] : v3_decode_type(data_word[31:16], cfg);
      trig_pos       = {1'b0, data_word} + TRIG_POS_OFFSET;
      bank_id        = v2_ff ? {4'b0, data_word[23:16]} : data_word[27:16];
      bank_len       = v2_ff ? pend_len_ff : pend_len_ff + 32'd1;
      bank_next      = {1'b0, next_pos_ff} + {1'b0, bank_len} + {32'b0, v2_ff};
      last_index     = (word_index_ff == WORD_LEN) ? data_word : event_words_ff;
      push           = '0;

      if (accept) begin
         len_seen_in = 1'b0;
         if (word_index_ff == WORD_LEN) begin
            event_words_in = data_word;
            v2_in          = (cfg.format_version == FMT_V2);
            cur_type_in    = '0;
            banks_in       = '0;
            status_in      = ST_OK;
            evnum_in       = '0;
            run_info_in    = '{default: '0};
            phys_in        = 1'b0;
            prestart_in    = 1'b0;
            armed_in       = 1'b0;
            walk_in        = 1'b0;
         end else if (word_index_ff == WORD_TYPE) begin
            cur_type_in = type_dec;
            prestart_in = (type_dec == cfg.prestart_type);
            phys_in     = !prestart_in && (type_dec <= cfg.max_physics_type);
            if (phys_in) begin
               if (v2_ff) begin
                  if (data_word[15:0] != HEADER_MARK) begin
                     status_in = ST_BAD_MARK;
                  end
                  armed_in = 1'b1;
               end else begin
                  v3_cnt_in = v3_cnt_ff + 32'd1;
                  evnum_in  = v3_cnt_ff + 32'd1;
                  if (type_dec == TRIGGER_EVENT) begin
                     trig_cnt_in = '0;
                     armed_in    = 1'b1;
                  end else begin
                     next_pos_in = FIRST_BANK_POS;
                     walk_in     = 1'b1;
                  end
               end
            end
         end else begin
            // trigger bank length places the first crate bank
            if (word_index_ff == WORD_TRIG_LEN && armed_ff) begin
               armed_in = 1'b0;
               if (!trig_pos[32]) begin
                  next_pos_in = trig_pos[31:0];
                  walk_in     = 1'b1;
               end
            end
            if (word_index_ff == WORD_TRIG_CNT && phys_ff && !v2_ff
                && cur_type_ff == TRIGGER_EVENT) begin
               trig_cnt_in = data_word[7:0];
            end
            if (word_index_ff == WORD_EVNUM && phys_ff && v2_ff) begin
               evnum_in = data_word;
            end
            if (prestart_ff && word_index_ff <= WORD_EVNUM) begin
               case (word_index_ff[2:0])
                  3'd2:    run_info_in[0] = data_word;
                  3'd3:    run_info_in[1] = data_word;
                  3'd4:    run_info_in[2] = data_word;
                  default: run_info_in[0] = run_info_ff[0];
               endcase
            end

            // len_seen_ff marks that the previous word was a bank length
            if (walk_ff) begin
               if (len_seen_ff) begin
                  if (banks_ff >= CRATE_CNT_W'(MAX_CRATES)) begin
                     walk_in = 1'b0;
                  end else if (v2_ff && {1'b0, data_word[23:16]} >= 9'(MAX_CRATES)) begin
                     if (status_in == ST_OK) begin
                        status_in = ST_BAD_CRATE;
                     end
                     walk_in = 1'b0;
                  end else begin
                     push.desc_valid         = 1'b1;
                     push.desc.kind          = KIND_BANK;
                     push.desc.crate_id      = bank_id;
                     push.desc.bank_position = next_pos_ff;
                     push.desc.bank_length   = bank_len;
                     push.desc.last          = 1'b1;
                     banks_in                = banks_ff + CRATE_CNT_W'(1);
                     if (bank_len == '0 && !v2_ff) begin
                        walk_in = 1'b0;
                     end else if (bank_next[32]) begin
                        walk_in = 1'b0;
                     end else begin
                        next_pos_in = bank_next[31:0];
                        // empty bank: next length word is this very word
                        if (pend_len_ff == '0) begin
                           pend_len_in = data_word;
                           len_seen_in = 1'b1;
                        end
                     end
                  end
               end else if (word_index_ff == next_pos_ff) begin
                  pend_len_in = data_word;
                  len_seen_in = 1'b1;
               end
            end
         end

         if (word_index_ff == last_index) begin
            if (phys_in && !v2_in && banks_in != {4'b0, trig_cnt_in}
                && status_in == ST_OK) begin
               status_in = ST_COUNT_MISMATCH;
            end
            push.sum_valid        = 1'b1;
            push.sum.kind         = KIND_SUMMARY;
            push.sum.event_code   = cur_type_in;
            push.sum.event_number = phys_in ? evnum_in : '0;
            push.sum.crate_count  = banks_in;
            push.sum.status       = status_in;
            push.sum.run_time     = prestart_in ? run_info_in[0] : '0;
            push.sum.run_number   = prestart_in ? run_info_in[1] : '0;
            push.sum.run_kind     = prestart_in ? run_info_in[2] : '0;
            push.sum.last         = 1'b1;
            push.desc.last        = 1'b0;
            word_index_in         = '0;
            walk_in               = 1'b0;
            armed_in              = 1'b0;
            len_seen_in           = 1'b0;
         end else begin
            word_index_in = word_index_ff + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_index_ff  <= '0;
         event_words_ff <= '0;
         cur_type_ff    <= '0;
         next_pos_ff    <= '0;
         pend_len_ff    <= '0;
         banks_ff       <= '0;
         trig_cnt_ff    <= '0;
         v3_cnt_ff      <= '0;
         evnum_ff       <= '0;
         run_info_ff    <= '{default: '0};
         status_ff      <= ST_OK;
         v2_ff          <= 1'b0;
         phys_ff        <= 1'b0;
         prestart_ff    <= 1'b0;
         armed_ff       <= 1'b0;
         walk_ff        <= 1'b0;
         len_seen_ff    <= 1'b0;
      end else begin
         word_index_ff  <= word_index_in;
         event_words_ff <= event_words_in;
         cur_type_ff    <= cur_type_in;
         next_pos_ff    <= next_pos_in;
         pend_len_ff    <= pend_len_in;
         banks_ff       <= banks_in;
         trig_cnt_ff    <= trig_cnt_in;
         v3_cnt_ff      <= v3_cnt_in;
         evnum_ff       <= evnum_in;
         run_info_ff    <= run_info_in;
         status_ff      <= status_in;
         v2_ff          <= v2_in;
         phys_ff        <= phys_in;
         prestart_ff    <= prestart_in;
         armed_ff       <= armed_in;
         walk_ff        <= walk_in;
         len_seen_ff    <= len_seen_in;
      end
   end

endmodule

>>> hdl/daq_ebd_rsp_queue.sv
// ----------------------------------------------------------------------------
// daq_ebd_rsp_queue
// Small response queue: takes up to two responses a cycle and gives one on each pop.
// ----------------------------------------------------------------------------
module daq_ebd_rsp_queue import daq_ebd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  push_type     push,
   input  logic         pop,
   output rsp_item_type head,
   output logic         head_valid,
   output logic         two_free
);

   rsp_item_type         q_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff,  count_in;
   logic [Q_CNT_W-1:0]   push_n;
   logic [Q_PTR_W-1:0]   sum_ptr;

   assign head       = q_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);
   assign two_free   = (count_ff <= Q_CNT_W'(Q_DEPTH - 2));

   always_comb begin
      push_n    = Q_CNT_W'(push.desc_valid) + Q_CNT_W'(push.sum_valid);
      sum_ptr   = push.desc_valid ? wr_ptr_ff + Q_PTR_W'(1) : wr_ptr_ff;
      wr_ptr_in = wr_ptr_ff + push_n[Q_PTR_W-1:0];
      rd_ptr_in = rd_ptr_ff + Q_PTR_W'(pop && head_valid);
      count_in  = count_ff + push_n - Q_CNT_W'(pop && head_valid);
   end

   always_ff @(posedge clock) begin
      if (push.desc_valid) begin
         q_ff[wr_ptr_ff] <= push.desc;
      end
      if (push.sum_valid) begin
         q_ff[sum_ptr] <= push.sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> hdl/daq_ebd_checker.sv
// ----------------------------------------------------------------------------
// daq_ebd_checker
// Port-level checks on the deframer's response channel.
// ----------------------------------------------------------------------------
module daq_ebd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_kind,
   input logic        rsp_last,
   input logic [11:0] rsp_crate_id,
   input logic [31:0] rsp_bank_length,
   input logic [31:0] rsp_bank_position,
   input logic [1:0]  rsp_status
);

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_bank_position) && $stable(rsp_status))
      else $error("stalled response changed");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a descriptor not marked last is followed by its event summary
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_kind && !rsp_last |=> rsp_valid && rsp_kind)
      else $error("summary missing after descriptor");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind |-> rsp_last && rsp_crate_id == 12'd0
         && rsp_bank_length == 32'd0)
      else $error("malformed event summary");

endmodule

bind daq_event_bank_deframer daq_ebd_checker u_daq_ebd_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_kind          (rsp_ch.kind),
   .rsp_last          (rsp_ch.last),
   .rsp_crate_id      (rsp_ch.crate_id),
   .rsp_bank_length   (rsp_ch.bank_length),
   .rsp_bank_position (rsp_ch.bank_position),
   .rsp_status        (rsp_ch.status)
);

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the event bank deframer. A driver feeds stream
// words from a queue with random gaps, a monitor takes responses with random
// back-pressure, and an in-bench deframer predicts every bank descriptor and
// event summary. Directed events come first, then random events in phases
// that each run under their own register settings.
// ----------------------------------------------------------------------------
module tb;
   import daq_ebd_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE      = 8;
   localparam int PHASES      = 11;
   localparam int PHASE_WORDS = 76;

   typedef enum int {EV_PHYS, EV_PRESTART, EV_CONTROL, EV_MISC, EV_TINY} ev_shape_type;

   logic clock = 1'b0;
   logic reset;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   daq_ebd_req_if req_ch ();
   daq_ebd_rsp_if rsp_ch ();

   daq_event_bank_deframer dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // register shadow
   logic [1:0]  cfg_version  = 2'd3;
   logic [15:0] cfg_max_phys = 16'd15;
   logic [15:0] cfg_prestart = 16'd17;
   logic [15:0] cfg_go       = 16'd18;
   logic [15:0] cfg_end      = 16'd20;

   // deframer state
   logic [31:0] ev_idx        = '0;
   logic [31:0] ev_last       = '0;
   logic [15:0] ev_type       = '0;
   logic [31:0] bank_pos      = '0;
   logic [31:0] bank_len_pend = '0;
   logic [11:0] banks_seen    = '0;
   logic [7:0]  trig_count    = '0;
   logic [31:0] v3_count      = '0;
   logic [31:0] ev_num        = '0;
   logic [31:0] run_words [3] = '{default: '0};
   status_type  ev_status     = ST_OK;
   logic ev_is_v2 = 1'b0, ev_is_phys = 1'b0, ev_is_prestart = 1'b0;
   logic walk_pending = 1'b0, walking = 1'b0;

   logic [31:0]  stream_words [$];
   rsp_item_type expected_rsp [$];
   rsp_item_type want_rsp;
   int unsigned  queued_cnt   = 0;
   int unsigned  accepted_cnt = 0;
   int unsigned  rsp_count    = 0;
   int unsigned  err_count    = 0;
   int unsigned  src_idle_pct = 37;
   int unsigned  snk_idle_pct = 37;

   // v3 events: one-word, trigger bank with one crate, short prestart,
   // crate length wrapping to zero on the last word
   logic [31:0] dir_v3 [16] = '{
      32'd0,
      32'd6, {TAG_PHYS_A, 16'h0000}, 32'd1, 32'hffff_ff01, 32'd1, 32'hffff_ffff,
      32'hffff_ffff,
      32'd3, {TAG_PRESTART, 16'hffff}, 32'hffff_ffff, 32'h0000_0000,
      32'd3, 32'h0000_0000, 32'hffff_ffff, 32'h0000_0000
   };
   // v2 events: good crate then illegal crate id, first bank position overflow
   logic [31:0] dir_v2 [13] = '{
      32'd7, {16'd3, HEADER_MARK}, 32'd0, 32'd1, 32'h001f_0000, 32'd1, 32'h0020_0000,
      32'd0,
      32'd4, {16'd0, HEADER_MARK}, 32'hffff_ffff, 32'd0, 32'd7
   };

   task automatic flag_fault(input status_type code);
      if (ev_status == ST_OK) ev_status = code;
   endtask

   task automatic deframe_word(input logic [31:0] w);
      rsp_item_type desc, summ;
      logic         have_desc, have_summ;
      logic [15:0]  tag;
      logic [32:0]  nxt;
      logic [11:0]  id;
      logic [31:0]  blen;
      desc = '0;
      summ = '0;
      have_desc = 1'b0;
      have_summ = 1'b0;
      tag = w[31:16];
      if (ev_idx == WORD_LEN) begin
         ev_last = w;
         ev_is_v2 = (cfg_version == FMT_V2);
         ev_type = '0;
         banks_seen = '0;
         ev_status = ST_OK;
         ev_num = '0;
         foreach (run_words[n]) run_words[n] = '0;
         ev_is_phys = 1'b0;
         ev_is_prestart = 1'b0;
         walk_pending = 1'b0;
         walking = 1'b0;
      end else if (ev_idx == WORD_TYPE) begin
         if (ev_is_v2 || tag < TAG_RESERVED_BASE) begin
            ev_type = tag;
         end else begin
            case (tag)
               TAG_PRESTART: ev_type = cfg_prestart;
               TAG_GO:       ev_type = cfg_go;
               TAG_END:      ev_type = cfg_end;
               TAG_PHYS_A, TAG_PHYS_B, TAG_PHYS_C: ev_type = TRIGGER_EVENT;
               default:      ev_type = '0;
            endcase
         end
         ev_is_prestart = (ev_type == cfg_prestart);
         ev_is_phys = !ev_is_prestart && ev_type <= cfg_max_phys;
         if (ev_is_phys) begin
            if (ev_is_v2) begin
               if (w[15:0] != HEADER_MARK) flag_fault(ST_BAD_MARK);
               walk_pending = 1'b1;
            end else begin
               v3_count = v3_count + 32'd1;
               ev_num = v3_count;
               if (ev_type == TRIGGER_EVENT) begin
                  trig_count = '0;
                  walk_pending = 1'b1;
               end else begin
                  bank_pos = FIRST_BANK_POS;
                  walking = 1'b1;
               end
            end
         end
      end else begin
         if (ev_idx == WORD_TRIG_LEN && walk_pending) begin
            nxt = {1'b0, w} + TRIG_POS_OFFSET;
            walk_pending = 1'b0;
            if (!nxt[32]) begin
               bank_pos = nxt[31:0];
               walking = 1'b1;
            end
         end
         if (ev_idx == WORD_TRIG_CNT && ev_is_phys && !ev_is_v2 && ev_type == TRIGGER_EVENT)
            trig_count = w[7:0];
         if (ev_idx == WORD_EVNUM && ev_is_phys && ev_is_v2) ev_num = w;
         if (ev_is_prestart && ev_idx <= WORD_EVNUM) run_words[ev_idx[1:0] - 2'd2] = w;

         if (walking) begin
            if (ev_idx == bank_pos) begin
               bank_len_pend = w;
            end else if ({1'b0, ev_idx} == {1'b0, bank_pos} + 33'd1) begin
               if (banks_seen >= MAX_CRATES) begin
                  walking = 1'b0;
               end else begin
                  if (ev_is_v2) begin
                     id = {4'd0, w[23:16]};
                     blen = bank_len_pend;
                     nxt = {1'b0, bank_pos} + {1'b0, blen} + 33'd1;
                  end else begin
                     id = w[27:16];
                     blen = bank_len_pend + 32'd1;
                     nxt = {1'b0, bank_pos} + {1'b0, blen};
                  end
                  if (ev_is_v2 && id >= MAX_CRATES) begin
                     flag_fault(ST_BAD_CRATE);
                     walking = 1'b0;
                  end else begin
                     desc.kind = KIND_BANK;
                     desc.crate_id = id;
                     desc.bank_position = bank_pos;
                     desc.bank_length = blen;
                     have_desc = 1'b1;
                     banks_seen = banks_seen + 12'd1;
                     if (blen == 0 && !ev_is_v2) begin
                        walking = 1'b0;
                     end else if (nxt[32]) begin
                        walking = 1'b0;
                     end else begin
                        bank_pos = nxt[31:0];
                        // empty bank: the next length word is this one
                        if (bank_pos == ev_idx) bank_len_pend = w;
                     end
                  end
               end
            end
         end
      end

      if (ev_idx == ev_last) begin
         if (ev_is_phys && !ev_is_v2 && banks_seen != {4'd0, trig_count})
            flag_fault(ST_COUNT_MISMATCH);
         summ.kind = KIND_SUMMARY;
         summ.event_code = ev_type;
         summ.event_number = ev_is_phys ? ev_num : '0;
         summ.crate_count = banks_seen;
         summ.status = ev_status;
         if (ev_is_prestart) begin
            summ.run_time = run_words[0];
            summ.run_number = run_words[1];
            summ.run_kind = run_words[2];
         end
         summ.last = 1'b1;
         have_summ = 1'b1;
         ev_idx = '0;
         walking = 1'b0;
         walk_pending = 1'b0;
      end else begin
         ev_idx = ev_idx + 32'd1;
      end

      if (have_desc) begin
         desc.last = !have_summ;
         expected_rsp.push_back(desc);
      end
      if (have_summ) expected_rsp.push_back(summ);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      err_count++;
      $display("response %0d: %s got %h want %h", rsp_count, what, got, want);
   endtask

   // driver: holds a request until it is taken
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            deframe_word(req_ch.data_word);
            accepted_cnt <= accepted_cnt + 1;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (stream_words.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
               req_ch.valid <= 1'b1;
               req_ch.data_word <= stream_words.pop_front();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_count++;
            if (expected_rsp.size() == 0) begin
               report_mismatch("response with none expected", '0, '0);
            end else begin
               want_rsp = expected_rsp.pop_front();
               if (rsp_ch.kind !== want_rsp.kind)
                  report_mismatch("kind", 32'(rsp_ch.kind), 32'(want_rsp.kind));
               if (rsp_ch.crate_id !== want_rsp.crate_id)
                  report_mismatch("crate_id", 32'(rsp_ch.crate_id),
                                  32'(want_rsp.crate_id));
               if (rsp_ch.bank_position !== want_rsp.bank_position)
                  report_mismatch("bank_position", rsp_ch.bank_position,
                                  want_rsp.bank_position);
               if (rsp_ch.bank_length !== want_rsp.bank_length)
                  report_mismatch("bank_length", rsp_ch.bank_length, want_rsp.bank_length);
               if (rsp_ch.event_code !== want_rsp.event_code)
                  report_mismatch("event_code", 32'(rsp_ch.event_code),
                                  32'(want_rsp.event_code));
               if (rsp_ch.event_number !== want_rsp.event_number)
                  report_mismatch("event_number", rsp_ch.event_number, want_rsp.event_number);
               if (rsp_ch.crate_count !== want_rsp.crate_count)
                  report_mismatch("crate_count", 32'(rsp_ch.crate_count),
                                  32'(want_rsp.crate_count));
               if (rsp_ch.status !== want_rsp.status)
                  report_mismatch("status", 32'(rsp_ch.status), 32'(want_rsp.status));
               if (rsp_ch.run_time !== want_rsp.run_time)
                  report_mismatch("run_time", rsp_ch.run_time, want_rsp.run_time);
               if (rsp_ch.run_number !== want_rsp.run_number)
                  report_mismatch("run_number", rsp_ch.run_number, want_rsp.run_number);
               if (rsp_ch.run_kind !== want_rsp.run_kind)
                  report_mismatch("run_kind", rsp_ch.run_kind, want_rsp.run_kind);
               if (rsp_ch.last !== want_rsp.last)
                  report_mismatch("last", 32'(rsp_ch.last), 32'(want_rsp.last));
            end
         end
         rsp_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
   end

   task automatic write_csr(input csr_index_type idx, input logic [15:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_FORMAT_VERSION:   cfg_version = val[1:0];
         CSR_MAX_PHYSICS_TYPE: cfg_max_phys = val;
         CSR_PRESTART_TYPE:    cfg_prestart = val;
         CSR_GO_TYPE:          cfg_go = val;
         CSR_END_TYPE:         cfg_end = val;
         default: ;
      endcase
   endtask

   task automatic apply_config(input logic [1:0] ver, input logic [15:0] max_phys,
                               input logic [15:0] pre, input logic [15:0] go,
                               input logic [15:0] fin);
      // upper data bits are junk for the version register
      write_csr(CSR_FORMAT_VERSION, {14'($urandom), ver});
      write_csr(CSR_MAX_PHYSICS_TYPE, max_phys);
      write_csr(CSR_PRESTART_TYPE, pre);
      write_csr(CSR_GO_TYPE, go);
      write_csr(CSR_END_TYPE, fin);
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      do @(negedge clock); while (accepted_cnt != queued_cnt || expected_rsp.size() != 0);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic add_event(input ev_shape_type shape);
      logic [31:0] ev [$];
      logic        v2, trig;
      logic [15:0] tag, top;
      int unsigned nb, hdr, sz, j, k, cut;
      v2 = (cfg_version == FMT_V2);
      ev.push_back('0);
      case (shape)
         EV_PHYS: begin
            nb = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 34) : $urandom_range(0, 4);
            top = (!v2 && cfg_max_phys > 16'hfeff) ? 16'hfeff : cfg_max_phys;
            tag = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, top));
            trig = !v2 && ($urandom_range(0, 1) == 1);
            if (trig) begin
               case ($urandom_range(0, 3))
                  0:       tag = TRIGGER_EVENT;
                  1:       tag = TAG_PHYS_A;
                  2:       tag = TAG_PHYS_B;
                  default: tag = TAG_PHYS_C;
               endcase
            end else if (!v2 && tag == TRIGGER_EVENT) begin
               tag = '0;
            end
            if (v2) begin
               ev.push_back({tag, ($urandom_range(0, 7) == 0) ? 16'($urandom) : HEADER_MARK});
               hdr = $urandom_range(0, 3);
               ev.push_back(hdr);
               for (k = 0; k < hdr; k++) ev.push_back($urandom);
            end else if (trig) begin
               ev.push_back({tag, 16'($urandom)});
               hdr = $urandom_range(1, 3);
               ev.push_back(hdr);
               ev.push_back({24'($urandom), ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'(nb)});
               for (k = 1; k < hdr; k++) ev.push_back($urandom);
            end else begin
               ev.push_back({tag, 16'($urandom)});
            end
            for (j = 0; j < nb; j++) begin
               sz = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 3);
               ev.push_back(sz);
               if (v2)
                  ev.push_back({8'($urandom),
                                ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                   : 8'($urandom_range(0, MAX_CRATES - 1)),
                                16'($urandom)});
               else
                  ev.push_back($urandom);
               for (k = 1; k < sz; k++) ev.push_back($urandom);
            end
            // bank length that runs past 32 bits or wraps to zero
            if ($urandom_range(0, 11) == 0) begin
               ev.push_back($urandom_range(0, 1) ? 32'hffff_ffff : 32'hffff_fffe);
               ev.push_back($urandom);
            end
            for (k = $urandom_range(0, 2); k > 0; k--) ev.push_back($urandom);
         end
         EV_PRESTART: begin
            ev.push_back({(v2 || $urandom_range(0, 3) == 0) ? cfg_prestart : TAG_PRESTART,
                          16'($urandom)});
            for (k = $urandom_range(0, 4); k > 0; k--) ev.push_back($urandom);
         end
         EV_CONTROL: begin
            if ($urandom_range(0, 1)) tag = v2 ? cfg_go : TAG_GO;
            else tag = v2 ? cfg_end : TAG_END;
            ev.push_back({tag, 16'($urandom)});
            for (k = $urandom_range(0, 3); k > 0; k--) ev.push_back($urandom);
         end
         EV_MISC: begin
            tag = $urandom_range(0, 1) ? {8'hff, 8'($urandom)} : 16'($urandom);
            ev.push_back({tag, 16'($urandom)});
            for (k = $urandom_range(0, 6); k > 0; k--) ev.push_back($urandom);
         end
         default: begin
            if ($urandom_range(0, 1)) ev.push_back($urandom);
         end
      endcase
      // truncated event: banks past the end are never reached
      if (shape != EV_TINY && $urandom_range(0, 9) == 0) begin
         cut = $urandom_range(1, ev.size() - 1);
         while (ev.size() > cut) void'(ev.pop_back());
      end
      ev[0] = ev.size() - 1;
      for (k = 0; k < ev.size(); k++) stream_words.push_back(ev[k]);
      queued_cnt += ev.size();
   endtask

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("TB_ERROR");
      $finish;
   end

   initial begin : stimulus
      int unsigned ph, mark, r;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data_word = '0;
      rsp_ch.ready = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_FORMAT_VERSION;
      csr_wdata = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_v3[n]) stream_words.push_back(dir_v3[n]);
      queued_cnt += $size(dir_v3);
      wait_idle();
      apply_config(FMT_V2, 16'd15, 16'd17, 16'd18, 16'd20);
      foreach (dir_v2[n]) stream_words.push_back(dir_v2[n]);
      queued_cnt += $size(dir_v2);
      wait_idle();

      for (ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: apply_config(2'd3, 16'd0, 16'd0, 16'hffff, 16'd0);
            1: apply_config(FMT_V2, 16'hffff, 16'hffff, 16'd0, 16'hffff);
            2: apply_config(2'd3, 16'hffff, 16'd1, 16'd2, 16'd3);
            3: apply_config(2'd0, 16'd15, 16'd17, 16'd18, 16'd20);
            4: apply_config(FMT_V2, 16'd15, 16'd17, 16'd18, 16'd20);
            default: apply_config(
               ($urandom_range(0, 4) == 0) ? 2'($urandom)
                  : ($urandom_range(0, 1) ? FMT_V2 : 2'd3),
               16'($urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom),
               16'($urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom),
               16'($urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom),
               16'($urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom));
         endcase
         // one phase runs with both sides at full rate
         src_idle_pct = (ph == 5) ? 0 : 37;
         snk_idle_pct = (ph == 5) ? 0 : 37;
         mark = queued_cnt;
         while (queued_cnt - mark < PHASE_WORDS) begin
            r = $urandom_range(0, 99);
            if (r < 60) add_event(EV_PHYS);
            else if (r < 70) add_event(EV_PRESTART);
            else if (r < 80) add_event(EV_CONTROL);
            else if (r < 92) add_event(EV_MISC);
            else add_event(EV_TINY);
         end
         wait_idle();
      end

      if (err_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule

>>> daq_event_bank_deframer.f
hdl/daq_ebd_pkg.sv
hdl/daq_ebd_if.sv
hdl/daq_ebd_parse.sv
hdl/daq_ebd_rsp_queue.sv
hdl/daq_event_bank_deframer.sv
hdl/daq_ebd_checker.sv
tb/tb.sv
